[src/wedi_pkg.sv]
// ----------------------------------------------------------------------------
// wedi_pkg: shared types and constants for the weighted edit distance core
// Widths of the item fields, command and mode codes, cell and scoring types,
// controller states and the saturating add used by the scoring datapath.
// ----------------------------------------------------------------------------
package wedi_pkg;

  localparam int ALPHABET_DEF = 32;
  localparam int MAX_LEN_DEF  = 64;

  localparam int SYM_W      = 5;
  localparam int COST_W     = 16;
  localparam int SCORE_W    = 31;
  localparam int DIST_W     = 32;
  localparam int IDENT_W    = 17;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 17;

  // shared divider sizing: Q23.8 dividend shifted by 16, divisor up to 32 bits
  localparam int DIVN_W = 48;
  localparam int DIVD_W = 32;

  localparam logic [SCORE_W-1:0] SCORE_SAT = '1;

  localparam logic [CFG_IDX_W-1:0] REG_NORM_MODE      = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_INDEL_COST     = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_IDENT_THRESHOLD = 2'd2;

  typedef enum logic [1:0] {
    CMD_COST    = 2'd0,
    CMD_PUSH_A  = 2'd1,
    CMD_PUSH_B  = 2'd2,
    CMD_COMPUTE = 2'd3
  } cmd_t;

  typedef enum logic [1:0] {
    NORM_RAW    = 2'd0,
    NORM_LONGER = 2'd1,
    NORM_SQRT   = 2'd2,
    NORM_MAX    = 2'd3
  } norm_t;

  typedef enum logic [1:0] {
    DIR_NONE = 2'd0,
    DIR_INS  = 2'd1,
    DIR_DEL  = 2'd2,
    DIR_SUB  = 2'd3
  } dir_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_INIT,
    ST_ROW_A,
    ST_ROW_C,
    ST_ROW_RUN,
    ST_MAXD1,
    ST_MAXD2,
    ST_NORM,
    ST_SQRT,
    ST_DIV_NORM,
    ST_TB_INIT,
    ST_TB_STEP,
    ST_TB_EVAL,
    ST_ID,
    ST_DIV_ID,
    ST_FINISH
  } state_t;

  // one column of the running score row
  typedef struct packed {
    logic [SYM_W-1:0]   sym;
    logic [SCORE_W-1:0] score;
  } cell_t;

  typedef struct packed {
    logic [SCORE_W-1:0] score;
    dir_t               dir;
  } pe_out_t;

  function automatic logic [SCORE_W-1:0] sat_add(input logic [SCORE_W-1:0] a,
                                                 input logic [SCORE_W-1:0] b);
    logic [SCORE_W:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[SCORE_W] ? SCORE_SAT : s[SCORE_W-1:0];
  endfunction

endpackage

[src/wedi_cell.sv]
// ----------------------------------------------------------------------------
// wedi_cell: one link of the score row chain
// Holds a B symbol and its column score; takes its neighbor's content on shift.
// ----------------------------------------------------------------------------
module wedi_cell
  import wedi_pkg::*;
(
  input  logic             clk,
  input  logic             shift_en,
  input  cell_t            nbr,
  input  logic             load_en,
  input  logic [SYM_W-1:0] load_sym,
  output cell_t            content
);

  always_ff @(posedge clk) begin
    if (shift_en) begin
      content <= nbr;
    end else if (load_en) begin
      content.sym <= load_sym;
    end
  end

endmodule

[src/wedi_pe.sv]
// ----------------------------------------------------------------------------
// wedi_pe: alignment cell evaluator
// Saturating insert / delete / substitute sums and the tie-ordered minimum.
// ----------------------------------------------------------------------------
module wedi_pe
  import wedi_pkg::*;
(
  input  logic [SCORE_W-1:0] left,
  input  logic [SCORE_W-1:0] up,
  input  logic [SCORE_W-1:0] diag,
  input  logic [COST_W-1:0]  cost,
  input  logic               eq,
  input  logic [SCORE_W-1:0] indel,
  output pe_out_t            res
);

  logic [SCORE_W-1:0] sub_cost;
  logic [SCORE_W-1:0] ins_sum;
  logic [SCORE_W-1:0] del_sum;
  logic [SCORE_W-1:0] sub_sum;

  assign sub_cost = eq ? '0 : SCORE_W'({cost, 8'h00});
  assign ins_sum  = sat_add(left, indel);
  assign del_sum  = sat_add(up, indel);
  assign sub_sum  = sat_add(diag, sub_cost);

  // insert wins ties, then delete
  always_comb begin
    res.score = ins_sum;
    res.dir   = DIR_INS;
    if (del_sum < res.score) begin
      res.score = del_sum;
      res.dir   = DIR_DEL;
    end
    if (sub_sum < res.score) begin
      res.score = sub_sum;
      res.dir   = DIR_SUB;
    end
  end

endmodule

[src/wedi_div.sv]
// ----------------------------------------------------------------------------
// wedi_div: restoring divider, one quotient bit per cycle
// Quotient is ready when done pulses; done pulses for one cycle.
// ----------------------------------------------------------------------------
module wedi_div
  import wedi_pkg::*;
#(
  parameter int N_W = DIVN_W,
  parameter int D_W = DIVD_W
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           start,
  input  logic [N_W-1:0] dividend,
  input  logic [D_W-1:0] divisor,
  output logic           done,
  output logic [N_W-1:0] quotient
);

  localparam int CNT_W = $clog2(N_W + 1);

  logic [D_W-1:0]   rem;
  logic [D_W-1:0]   den;
  logic [CNT_W-1:0] count;
  logic             busy;
  logic [D_W:0]     shifted;
  logic [D_W:0]     trial;
  logic             fits;

  assign shifted = {rem, quotient[N_W-1]};
  assign trial   = shifted - {1'b0, den};
  assign fits    = !trial[D_W];

  always_ff @(posedge clk) begin
    if (rst) begin
      busy  <= 1'b0;
      done  <= 1'b0;
      count <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy  <= 1'b1;
        count <= CNT_W'(N_W);
      end else if (busy) begin
        count <= count - 1'b1;
        if (count == CNT_W'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      quotient <= dividend;
      rem      <= '0;
      den      <= divisor;
    end else if (busy) begin
      rem      <= fits ? trial[D_W-1:0] : shifted[D_W-1:0];
      quotient <= {quotient[N_W-2:0], fits};
    end
  end

endmodule

[src/wedi_sqrt.sv]
// ----------------------------------------------------------------------------
// wedi_sqrt: integer square root, one result bit per cycle
// Digit-by-digit method; the root is ready when done pulses.
// ----------------------------------------------------------------------------
module wedi_sqrt
  import wedi_pkg::*;
#(
  parameter int W = 2 * 7 + 32
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  input  logic [W-1:0]     value,
  output logic             done,
  output logic [W/2-1:0]   root
);

  localparam int STEPS = W / 2;
  localparam int CNT_W = $clog2(STEPS + 1);

  logic [W-1:0]     rem;
  logic [W-1:0]     acc;
  logic [W-1:0]     probe;
  logic [CNT_W-1:0] count;
  logic             busy;
  logic [W-1:0]     trial;

  assign trial = acc + probe;
  assign root  = acc[W/2-1:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      busy  <= 1'b0;
      done  <= 1'b0;
      count <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy  <= 1'b1;
        count <= CNT_W'(STEPS);
      end else if (busy) begin
        count <= count - 1'b1;
        if (count == CNT_W'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem   <= value;
      acc   <= '0;
      probe <= W'(1) << (W - 2);
    end else if (busy) begin
      if (rem >= trial) begin
        rem <= rem - trial;
        acc <= (acc >> 1) + probe;
      end else begin
        acc <= acc >> 1;
      end
      probe <= probe >> 2;
    end
  end

endmodule

[src/weighted_edit_distance_identity_core.sv]
// ----------------------------------------------------------------------------
// weighted_edit_distance_identity_core: global alignment cost and identity
// Substitution table and two symbol sequences are loaded beat by beat; a
// compute beat aligns them, normalizes the cost and reports Q1.16 identity.
// ----------------------------------------------------------------------------
// Usage: load beats (cost entry, push A, push B) are taken only while idle.
// A compute beat runs the score matrix, then the worst-case cost, then the
// normalization (none, a divide, or a square root plus a divide), then the
// traceback and the identity divide.
// The score row sits in a chain of MAX_LEN cells that rotates once per matrix
// row past a single evaluator, so every row runs the whole chain whatever
// length_b is; the directions go to a (MAX_LEN+1)^2 x 3 bit memory that the
// traceback reads back. One result beat per compute.
// Both sequences are empty again after a compute. The result register lets a
// new beat in while the previous result waits to be taken.
// ----------------------------------------------------------------------------
module weighted_edit_distance_identity_core
  import wedi_pkg::*;
#(
  parameter int ALPHABET = ALPHABET_DEF,
  parameter int MAX_LEN  = MAX_LEN_DEF
) (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     item_valid,
  output logic                     item_ready,
  input  logic [1:0]               command,
  input  logic [SYM_W-1:0]         symbol,
  input  logic [SYM_W-1:0]         column,
  input  logic [COST_W-1:0]        cost_value,
  output logic                     result_valid,
  input  logic                     result_ready,
  output logic signed [DIST_W-1:0] distance,
  output logic [SCORE_W-1:0]       raw_distance,
  output logic [IDENT_W-1:0]       identity,
  output logic                     above_threshold,
  input  logic                     cfg_valid,
  output logic                     cfg_ready,
  input  logic [CFG_IDX_W-1:0]     cfg_index,
  input  logic [CFG_DATA_W-1:0]    cfg_data
);

  localparam int LEN_W     = $clog2(MAX_LEN + 1);
  localparam int IDX_W     = (MAX_LEN > 1) ? $clog2(MAX_LEN) : 1;
  localparam int DIR_DEPTH = (MAX_LEN + 1) * (MAX_LEN + 1);
  localparam int DA_W      = $clog2(DIR_DEPTH);
  localparam int CA_DEPTH  = ALPHABET * ALPHABET;
  localparam int CA_W      = $clog2(CA_DEPTH);
  localparam int NEXT      = (MAX_LEN > 1) ? 1 : 0;
  localparam int PRD_W     = LEN_W + 25;
  localparam int SQ_W      = 2 * LEN_W + 32;
  localparam int NW_W      = DIVN_W + 2;

  localparam logic [DA_W-1:0]   ROW_STEP  = DA_W'(MAX_LEN + 1);
  localparam logic [DA_W-1:0]   DIAG_STEP = DA_W'(MAX_LEN + 2);
  localparam logic [LEN_W-1:0]  LEN_MAX   = LEN_W'(MAX_LEN);
  localparam logic [DIST_W-1:0] ONE_Q16   = DIST_W'(65536);
  localparam logic [DIST_W-1:0] DIST_MAX  = 32'h7FFF_FFFF;
  localparam logic [DIST_W-1:0] DIST_MIN  = 32'h8000_0000;

  // control
  state_t state, state_next;
  cmd_t   cmd;
  logic   item_fire;
  logic   sym_ok, col_ok;

  // configuration and load state
  norm_t                norm_mode;
  logic [COST_W-1:0]    indel_cost;
  logic [IDENT_W-1:0]   identity_threshold;
  logic [COST_W-1:0]    max_sub_cost;
  logic [LEN_W-1:0]     length_a, length_b;
  logic [SCORE_W-1:0]   indel_q16;

  // memories
  logic [COST_W-1:0] cost_mem [CA_DEPTH];
  logic [COST_W-1:0] cost_q;
  logic [SYM_W-1:0]  cost_rsym;
  logic [SYM_W-1:0]  a_mem [MAX_LEN];
  logic [SYM_W-1:0]  a_q;
  logic [2:0]        dir_mem [DIR_DEPTH];
  logic [2:0]        dir_q;
  dir_t              tb_dir;

  // score chain and evaluator
  cell_t              cells [MAX_LEN];
  cell_t              tail_in;
  logic               shift_en;
  logic [MAX_LEN-1:0] b_load;
  pe_out_t            pe_res;
  logic               eq;
  logic [SCORE_W-1:0] acc, acc_next, col0, col0_next, left_q, diag_q, raw;
  logic [LEN_W-1:0]   row, col;
  logic [DA_W-1:0]    rbase;

  // worst case and normalization
  logic [PRD_W-1:0]   prod_len, prod_sub;
  logic [PRD_W:0]     md_sum;
  logic [2*LEN_W-1:0] prod_ll;
  logic [LEN_W-1:0]   longer, shorter, len_diff;
  logic [24:0]        maxs;
  logic [SCORE_W-1:0] maxdist, mag;
  logic               diff_neg;
  logic [DIST_W-1:0]  norm_dist;
  logic signed [NW_W-1:0] norm_wide;
  logic               raw_zero, longer_zero, len_zero;

  // traceback and identity
  logic [DA_W-1:0]    tb_addr;
  logic [LEN_W-1:0]   tb_i, tb_j, match_cnt;
  logic [IDENT_W-1:0] ident;
  logic               can_load;

  // shared arithmetic units
  logic               div_start, div_done;
  logic [DIVN_W-1:0]  div_dividend, div_quot;
  logic [DIVD_W-1:0]  div_divisor;
  logic               sq_start, sq_done;
  logic [SQ_W/2-1:0]  sq_root;

  assign cmd        = cmd_t'(command);
  assign item_fire  = item_valid && item_ready;
  assign sym_ok     = 32'(symbol) < 32'(ALPHABET);
  assign col_ok     = 32'(column) < 32'(ALPHABET);
  assign indel_q16  = SCORE_W'({indel_cost, 8'h00});
  assign cfg_ready  = 1'b1;
  assign raw_zero    = (raw == '0);
  assign longer_zero = (longer == '0);
  assign len_zero    = (length_a == '0) || (length_b == '0);
  assign acc_next   = sat_add(acc, indel_q16);
  assign col0_next  = sat_add(col0, indel_q16);
  assign eq         = (a_q == cells[0].sym);
  assign tb_dir     = dir_t'(dir_q[1:0]);
  assign can_load   = !result_valid || result_ready;
  assign md_sum     = {1'b0, prod_len} + {1'b0, prod_sub};
  // worst-case cost, held by the product registers from ST_NORM onward
  assign maxdist    = (md_sum > (PRD_W+1)'(SCORE_SAT)) ? SCORE_SAT : md_sum[SCORE_W-1:0];

  // ---------------------------------------------------------------------------
  // Score row chain: cell k holds column k+1; the head feeds the evaluator and
  // the new score re-enters at the tail, so a full rotation restores order.
  // ---------------------------------------------------------------------------
  for (genvar k = 0; k < MAX_LEN; k++) begin : g_chain
    cell_t nbr;
    assign nbr       = (k == MAX_LEN - 1) ? tail_in : cells[(k + 1) % MAX_LEN];
    assign b_load[k] = item_fire && (cmd == CMD_PUSH_B) && sym_ok &&
                       (length_b < LEN_MAX) && (length_b == LEN_W'(k));
    wedi_cell u_cell (
      .clk      (clk),
      .shift_en (shift_en),
      .nbr      (nbr),
      .load_en  (b_load[k]),
      .load_sym (symbol),
      .content  (cells[k])
    );
  end

  wedi_pe u_pe (
    .left  (left_q),
    .up    (cells[0].score),
    .diag  (diag_q),
    .cost  (cost_q),
    .eq    (eq),
    .indel (indel_q16),
    .res   (pe_res)
  );

  wedi_div #(.N_W(DIVN_W), .D_W(DIVD_W)) u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (div_dividend),
    .divisor  (div_divisor),
    .done     (div_done),
    .quotient (div_quot)
  );

  wedi_sqrt #(.W(SQ_W)) u_sqrt (
    .clk   (clk),
    .rst   (rst),
    .start (sq_start),
    .value ({prod_ll, 32'h0000_0000}),
    .done  (sq_done),
    .root  (sq_root)
  );

  // ---------------------------------------------------------------------------
  // Next state
  // ---------------------------------------------------------------------------
  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (item_fire && cmd == CMD_COMPUTE) state_next = ST_INIT;
      end
      ST_INIT: begin
        if (col == LEN_MAX) state_next = ST_ROW_A;
      end
      ST_ROW_A: begin
        state_next = (row == length_a) ? ST_MAXD1 : ST_ROW_C;
      end
      ST_ROW_C:   state_next = ST_ROW_RUN;
      ST_ROW_RUN: begin
        if (col == LEN_MAX) state_next = ST_ROW_A;
      end
      ST_MAXD1:   state_next = ST_MAXD2;
      ST_MAXD2:   state_next = ST_NORM;
      ST_NORM: begin
        state_next = ST_TB_INIT;
        if (!raw_zero) begin
          case (norm_mode)
            NORM_LONGER: if (!longer_zero) state_next = ST_DIV_NORM;
            NORM_SQRT:   if (!len_zero) state_next = ST_SQRT;
            NORM_MAX:    if (maxdist != '0) state_next = ST_DIV_NORM;
            default:     state_next = ST_TB_INIT;
          endcase
        end
      end
      ST_SQRT: begin
        if (sq_done) state_next = ST_DIV_NORM;
      end
      ST_DIV_NORM: begin
        if (div_done) state_next = ST_TB_INIT;
      end
      ST_TB_INIT: state_next = ST_TB_STEP;
      ST_TB_STEP: begin
        if (tb_i == '0 && tb_j == '0) state_next = ST_ID;
        else if (tb_i != '0 && tb_j != '0) state_next = ST_TB_EVAL;
      end
      ST_TB_EVAL: state_next = ST_TB_STEP;
      ST_ID:      state_next = longer_zero ? ST_FINISH : ST_DIV_ID;
      ST_DIV_ID: begin
        if (div_done) state_next = ST_FINISH;
      end
      ST_FINISH: begin
        if (can_load) state_next = ST_IDLE;
      end
      default:    state_next = ST_IDLE;
    endcase
  end

  // ---------------------------------------------------------------------------
  // Strobes and unit operands
  // ---------------------------------------------------------------------------
  always_comb begin
    item_ready   = (state == ST_IDLE);
    shift_en     = (state == ST_INIT) || (state == ST_ROW_RUN);
    tail_in.sym  = cells[0].sym;
    tail_in.score = (state == ST_INIT) ? acc_next : pe_res.score;
    cost_rsym    = (state == ST_ROW_C) ? cells[0].sym : cells[NEXT].sym;
    sq_start     = 1'b0;
    div_start    = 1'b0;
    div_dividend = DIVN_W'(raw);
    div_divisor  = DIVD_W'(longer);
    case (state)
      ST_NORM: begin
        sq_start = !raw_zero && (norm_mode == NORM_SQRT) && !len_zero;
        div_start = !raw_zero &&
                    (((norm_mode == NORM_LONGER) && !longer_zero) ||
                     ((norm_mode == NORM_MAX) && (maxdist != '0)));
        if (norm_mode == NORM_MAX) begin
          div_dividend = DIVN_W'({raw, 16'h0000});
          div_divisor  = DIVD_W'(maxdist);
        end
      end
      ST_SQRT: begin
        div_start    = sq_done;
        div_dividend = DIVN_W'({mag, 16'h0000});
        div_divisor  = DIVD_W'({sq_root, 1'b0});
      end
      ST_ID: begin
        div_start    = !longer_zero;
        div_dividend = DIVN_W'({match_cnt, 16'h0000});
      end
      default: begin
        div_start = 1'b0;
      end
    endcase
  end

  // sqrt-mode result: 1.0 plus or minus the quotient, clamped to 32 bits
  always_comb begin
    if (diff_neg) norm_wide = $signed(NW_W'(ONE_Q16)) + $signed({2'b00, div_quot});
    else          norm_wide = $signed(NW_W'(ONE_Q16)) - $signed({2'b00, div_quot});
  end

  // ---------------------------------------------------------------------------
  // Memories
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (item_fire && cmd == CMD_COST && sym_ok && col_ok) begin
      cost_mem[CA_W'(32'(symbol) * ALPHABET + 32'(column))] <= cost_value;
    end
    cost_q <= cost_mem[CA_W'(32'(a_q) * ALPHABET + 32'(cost_rsym))];
  end

  always_ff @(posedge clk) begin
    if (item_fire && cmd == CMD_PUSH_A && sym_ok && length_a < LEN_MAX) begin
      a_mem[length_a[IDX_W-1:0]] <= symbol;
    end
    if (state == ST_ROW_A) begin
      a_q <= a_mem[row[IDX_W-1:0]];
    end
  end

  // {match, direction} per matrix cell, rows and columns from 1
  always_ff @(posedge clk) begin
    if (state == ST_ROW_RUN) begin
      dir_mem[rbase + DA_W'(col)] <= {eq, pe_res.dir};
    end
    if (state == ST_TB_STEP) begin
      dir_q <= dir_mem[tb_addr];
    end
  end

  // ---------------------------------------------------------------------------
  // Control registers
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (rst) begin
      state              <= ST_IDLE;
      result_valid       <= 1'b0;
      norm_mode          <= NORM_RAW;
      indel_cost         <= COST_W'(256);
      identity_threshold <= '0;
      max_sub_cost       <= '0;
      length_a           <= '0;
      length_b           <= '0;
    end else begin
      state <= state_next;

      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          REG_NORM_MODE:       norm_mode <= norm_t'(cfg_data[1:0]);
          REG_INDEL_COST:      indel_cost <= cfg_data[COST_W-1:0];
          REG_IDENT_THRESHOLD: identity_threshold <= cfg_data;
          default:             norm_mode <= norm_mode;
        endcase
      end

      if (item_fire) begin
        case (cmd)
          CMD_COST: begin
            if (sym_ok && col_ok && symbol <= column && cost_value > max_sub_cost) begin
              max_sub_cost <= cost_value;
            end
          end
          CMD_PUSH_A: begin
            if (sym_ok && length_a < LEN_MAX) length_a <= length_a + 1'b1;
          end
          CMD_PUSH_B: begin
            if (sym_ok && length_b < LEN_MAX) length_b <= length_b + 1'b1;
          end
          default: begin
            length_a <= length_a;
          end
        endcase
      end

      if (state == ST_FINISH && can_load) begin
        result_valid <= 1'b1;
        length_a     <= '0;
        length_b     <= '0;
      end else if (result_ready) begin
        result_valid <= 1'b0;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Datapath
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    case (state)
      ST_IDLE: begin
        row   <= '0;
        col   <= LEN_W'(1);
        acc   <= '0;
        col0  <= '0;
        raw   <= '0;
        rbase <= '0;
      end
      // row 0: column j scores j * indel
      ST_INIT: begin
        acc <= acc_next;
        col <= col + 1'b1;
        if (col == length_b) raw <= acc_next;
      end
      ST_ROW_A: begin
        if (row != length_a) row <= row + 1'b1;
      end
      ST_ROW_C: begin
        diag_q <= col0;
        left_q <= col0_next;
        col0   <= col0_next;
        rbase  <= rbase + ROW_STEP;
        col    <= LEN_W'(1);
        if (length_b == '0) raw <= col0_next;
      end
      ST_ROW_RUN: begin
        left_q <= pe_res.score;
        diag_q <= cells[0].score;
        col    <= col + 1'b1;
        if (col == length_b) raw <= pe_res.score;
      end
      ST_MAXD1: begin
        len_diff <= (length_a > length_b) ? length_a - length_b : length_b - length_a;
        shorter  <= (length_a < length_b) ? length_a : length_b;
        longer   <= (length_a > length_b) ? length_a : length_b;
        maxs     <= (25'({max_sub_cost, 8'h00}) > 25'({indel_q16, 1'b0}))
                    ? 25'({indel_q16, 1'b0}) : 25'({max_sub_cost, 8'h00});
        prod_ll  <= (2*LEN_W)'(length_a) * (2*LEN_W)'(length_b);
      end
      ST_MAXD2: begin
        prod_len <= PRD_W'(len_diff) * PRD_W'(indel_q16);
        prod_sub <= PRD_W'(maxs) * PRD_W'(shorter);
      end
      ST_NORM: begin
        norm_dist <= '0;
        if (!raw_zero) begin
          case (norm_mode)
            NORM_RAW:    norm_dist <= DIST_W'(raw);
            NORM_SQRT:   if (len_zero) norm_dist <= (length_a != length_b) ? ONE_Q16 : '0;
            NORM_MAX:    if (maxdist == '0) norm_dist <= ONE_Q16;
            default:     norm_dist <= '0;
          endcase
        end
      end
      ST_SQRT: begin
        diff_neg <= raw > maxdist;
        mag      <= (raw > maxdist) ? raw - maxdist : maxdist - raw;
      end
      ST_DIV_NORM: begin
        if (div_done) begin
          case (norm_mode)
            NORM_SQRT: begin
              if (norm_wide > $signed(NW_W'(DIST_MAX))) norm_dist <= DIST_MAX;
              else if (norm_wide < -$signed(NW_W'(DIST_MIN))) norm_dist <= DIST_MIN;
              else norm_dist <= norm_wide[DIST_W-1:0];
            end
            NORM_MAX: begin
              norm_dist <= (|div_quot[DIVN_W-1:DIST_W-1]) ? DIST_MAX : div_quot[DIST_W-1:0];
            end
            default:   norm_dist <= div_quot[DIST_W-1:0];
          endcase
        end
      end
      // walk back from the corner; the edges move straight without using the read
      ST_TB_INIT: begin
        tb_i      <= length_a;
        tb_j      <= length_b;
        tb_addr   <= rbase + DA_W'(length_b);
        match_cnt <= '0;
      end
      ST_TB_STEP: begin
        if (tb_i == '0 && tb_j != '0) begin
          tb_j    <= tb_j - 1'b1;
          tb_addr <= tb_addr - 1'b1;
        end else if (tb_j == '0 && tb_i != '0) begin
          tb_i    <= tb_i - 1'b1;
          tb_addr <= tb_addr - ROW_STEP;
        end
      end
      ST_TB_EVAL: begin
        case (tb_dir)
          DIR_SUB: begin
            if (dir_q[2]) match_cnt <= match_cnt + 1'b1;
            tb_i    <= tb_i - 1'b1;
            tb_j    <= tb_j - 1'b1;
            tb_addr <= tb_addr - DIAG_STEP;
          end
          DIR_DEL: begin
            tb_i    <= tb_i - 1'b1;
            tb_addr <= tb_addr - ROW_STEP;
          end
          default: begin
            tb_j    <= tb_j - 1'b1;
            tb_addr <= tb_addr - 1'b1;
          end
        endcase
      end
      ST_ID: begin
        ident <= '0;
      end
      ST_DIV_ID: begin
        if (div_done) ident <= div_quot[IDENT_W-1:0];
      end
      ST_FINISH: begin
        if (can_load) begin
          distance        <= norm_dist;
          raw_distance    <= raw;
          identity        <= ident;
          above_threshold <= ident > identity_threshold;
        end
      end
      default: begin
        row <= row;
      end
    endcase
  end

endmodule
